[design/ccs_pkg.sv]
// Shared types and character constants for the C comment stripper.
// No dependencies; imported by every module of the block.
package ccs_pkg;

    // Characters that steer the scanner.
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Scanner mode; code 7 is never reached.
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_BSTAR  = 3'd4,
        MODE_BSLASH = 3'd5,
        MODE_HALT   = 3'd6
    } mode_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       nested_error;
        logic       last_of_run;
    } result_t;

    // Results caused by one input item: count of 0, 1 or 2, in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_t;

endpackage

[design/c_comment_stripper_top.sv]
// C comment stripper: input register, mode registers, scan logic, result queue.
// Depends on ccs_pkg, ccs_scan and ccs_out_fifo.
// Each input request is registered, then its results are written into the result queue.
// Throughput: one input request per cycle while the result queue has room; an
// item giving two results is sent one result at a time by the single-read queue.
// Reset (aresetn low, synchronous) empties both stages and sets normal text mode.
module c_comment_stripper_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte
    input  logic       s_axis_tlast,   // end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic       m_axis_tuser,   // nested_error
    output logic       m_axis_tlast    // last_of_run
);
    import ccs_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;
    mode_t      mode_reg, mode_next;
    logic       saw_nl_reg, saw_nl_next;
    step_t      step;
    step_t      push;
    logic       room;
    logic       fire;

    // The held request is processed when the queue has room for two results.
    assign fire = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || fire;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tlast;
        end
    end

    // Scan mode registers advance once per processed request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NORMAL;
            saw_nl_reg <= 1'b0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            saw_nl_reg <= saw_nl_next;
        end
    end

    ccs_scan u_scan (
        .mode_i       (mode_reg),
        .saw_nl_i     (saw_nl_reg),
        .data_byte    (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .mode_o       (mode_next),
        .saw_nl_o     (saw_nl_next),
        .step_o       (step)
    );

    // Only a processed request pushes results.
    always_comb begin
        push = step;
        if (!fire) begin
            push.count = 2'd0;
        end
    end

    ccs_out_fifo u_out_fifo (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push_i        (push),
        .room_o        (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[design/ccs_scan.sv]
// Per-byte transition logic of the comment stripper: next mode and results.
// Purely combinational; depends on ccs_pkg.
module ccs_scan (
    input  ccs_pkg::mode_t mode_i,
    input  logic           saw_nl_i,
    input  logic [7:0]     data_byte,
    input  logic           end_of_input,
    output ccs_pkg::mode_t mode_o,
    output logic           saw_nl_o,
    output ccs_pkg::step_t step_o
);
    import ccs_pkg::*;

    // Decode one item against the current mode.
    always_comb begin
        mode_o = mode_i;
        saw_nl_o = saw_nl_i;
        step_o.count = 2'd0;
        step_o.first = '{out_byte: data_byte, nested_error: 1'b0, last_of_run: 1'b1};
        step_o.second = '{out_byte: data_byte, nested_error: 1'b0, last_of_run: 1'b1};

        if (mode_i == MODE_HALT) begin
            mode_o = MODE_HALT;
        end else if (end_of_input) begin
            // End of text flushes a pending slash or the block padding.
            if (mode_i == MODE_SLASH) begin
                step_o.count = 2'd1;
                step_o.first.out_byte = CH_SLASH;
            end else if ((mode_i == MODE_BLOCK || mode_i == MODE_BSTAR ||
                          mode_i == MODE_BSLASH) && saw_nl_i) begin
                step_o.count = 2'd1;
                step_o.first.out_byte = CH_NEWLINE;
            end
            mode_o = MODE_NORMAL;
            saw_nl_o = 1'b0;
        end else begin
            unique case (mode_i)
                MODE_NORMAL: begin
                    if (data_byte == CH_SLASH) begin
                        mode_o = MODE_SLASH;
                    end else begin
                        step_o.count = 2'd1;
                    end
                end
                MODE_SLASH: begin
                    if (data_byte == CH_STAR) begin
                        mode_o = MODE_BLOCK;
                        saw_nl_o = 1'b0;
                    end else if (data_byte == CH_SLASH) begin
                        mode_o = MODE_LINE;
                    end else begin
                        // Lone slash: send it, then the byte itself.
                        step_o.count = 2'd2;
                        step_o.first.out_byte = CH_SLASH;
                        step_o.first.last_of_run = 1'b0;
                        mode_o = MODE_NORMAL;
                    end
                end
                MODE_LINE: begin
                    if (data_byte == CH_NEWLINE) begin
                        step_o.count = 2'd1;
                        mode_o = MODE_NORMAL;
                    end
                end
                MODE_BLOCK, MODE_BSTAR, MODE_BSLASH: begin
                    if (mode_i == MODE_BSLASH && data_byte == CH_STAR) begin
                        // Nested open comment: report and halt.
                        step_o.count = 2'd1;
                        step_o.first.out_byte = 8'd0;
                        step_o.first.nested_error = 1'b1;
                        mode_o = MODE_HALT;
                        saw_nl_o = 1'b0;
                    end else if (mode_i == MODE_BSTAR && data_byte == CH_SLASH) begin
                        if (saw_nl_i) begin
                            step_o.count = 2'd1;
                            step_o.first.out_byte = CH_NEWLINE;
                        end
                        mode_o = MODE_NORMAL;
                        saw_nl_o = 1'b0;
                    end else if (data_byte == CH_STAR) begin
                        mode_o = MODE_BSTAR;
                    end else if (data_byte == CH_SLASH) begin
                        mode_o = MODE_BSLASH;
                    end else begin
                        if (data_byte == CH_NEWLINE) begin
                            saw_nl_o = 1'b1;
                        end
                        mode_o = MODE_BLOCK;
                    end
                end
                default: begin
                    mode_o = MODE_NORMAL;
                end
            endcase
        end
    end

endmodule

[design/ccs_out_fifo.sv]
// Three-entry result queue: takes up to two results a cycle, sends one when the master side is ready.
// Depends on ccs_pkg for the result type.
module ccs_out_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  ccs_pkg::step_t   push_i,
    output logic             room_o,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_byte
    output logic             m_axis_tuser,   // nested_error
    output logic             m_axis_tlast    // last_of_run
);
    import ccs_pkg::*;

    localparam int unsigned DEPTH = 3;

    result_t    entry_reg [DEPTH];
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] wr_ptr_plus1;
    logic       pop;

    function automatic logic [1:0] inc3(input logic [1:0] p);
        logic [1:0] r;
        r = (p == 2'd2) ? 2'd0 : p + 2'd1;
        return r;
    endfunction

    assign pop = m_axis_tvalid && m_axis_tready;
    // Two free slots after this cycle's read are needed for any item.
    assign room_o = (count_reg - {1'b0, pop}) <= 2'd1;
    assign wr_ptr_plus1 = inc3(wr_ptr_reg);

    // Pointer and fill count update.
    always_comb begin
        rd_ptr_next = pop ? inc3(rd_ptr_reg) : rd_ptr_reg;
        unique case (push_i.count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = inc3(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg - {1'b0, pop} + push_i.count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 2'd0;
            wr_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge aclk) begin
        if (push_i.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push_i.first;
        end
        if (push_i.count == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push_i.second;
        end
    end

    // Head of the queue drives the result channel.
    assign m_axis_tvalid = count_reg != 2'd0;
    assign m_axis_tdata  = entry_reg[rd_ptr_reg].out_byte;
    assign m_axis_tuser  = entry_reg[rd_ptr_reg].nested_error;
    assign m_axis_tlast  = entry_reg[rd_ptr_reg].last_of_run;

endmodule
